### rtl/core/les_pkg.sv
`default_nettype none

package les_pkg;

    localparam int Q_W       = 32;
    localparam int PROD_W    = 48;
    localparam int NUM_COEFF = 4;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_STEP  = 1'b1;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } lane_ctl_t;

    typedef struct packed {
        q_t   q;
        logic clip;
    } sat_res_t;

    // Q16.16 product, low 16 bits dropped (floor)
    function automatic prod_t qmul(input q_t a, input q_t b);
        logic signed [2*Q_W-1:0] p;
        begin
            p = 64'(a) * 64'(b);
            return p[2*Q_W-1:16];
        end
    endfunction

    function automatic sat_res_t sat_q(input logic signed [63:0] x);
        sat_res_t r;
        begin
            r.clip = !((&x[63:Q_W-1]) || !(|x[63:Q_W-1]));
            if (r.clip)
            begin
                r.q = x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            else
            begin
                r.q = x[Q_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/les_lane.sv
`default_nettype none

module les_lane
    import les_pkg::*;
(
    input  wire logic      clk,
    input  wire lane_ctl_t ctl,
    input  wire q_t        coeff,
    input  wire q_t        v_self,
    input  wire q_t        v_up,
    input  wire q_t        step,
    output prod_t          coeff_prod,
    output q_t             next_val,
    output logic           clip
);

    prod_t    coeff_prod_reg;
    prod_t    shift_prod_reg;
    q_t       next_val_reg;
    logic     clip_reg;
    sat_res_t add_res;

    assign add_res = sat_q(64'(v_self) + 64'(shift_prod_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            coeff_prod_reg <= qmul(coeff, v_self);
            shift_prod_reg <= qmul(v_up, step);
        end
        if (ctl.add_en)
        begin
            next_val_reg <= add_res.q;
            clip_reg     <= add_res.clip;
        end
    end

    assign coeff_prod = coeff_prod_reg;
    assign next_val   = next_val_reg;
    assign clip       = clip_reg;

endmodule

`default_nettype wire

### rtl/core/les_merge.sv
`default_nettype none

module les_merge
    import les_pkg::*;
#(
    parameter int MAX_ORDER = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 sum_en,
    input  wire q_t                   forcing,
    input  wire prod_t                prod [MAX_ORDER],
    input  wire logic [MAX_ORDER-1:0] active,
    output q_t                        acc,
    output logic                      clip
);

    localparam int ACC_W = PROD_W + $clog2(MAX_ORDER + 1) + 1;

    logic signed [ACC_W-1:0] sum;
    sat_res_t                sum_res;
    q_t                      acc_reg;
    logic                    clip_reg;

    always_comb
    begin
        sum = ACC_W'(forcing);
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (active[k])
            begin
                sum = sum - ACC_W'(prod[k]);
            end
        end
        sum_res = sat_q(64'(sum));
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            acc_reg  <= sum_res.q;
            clip_reg <= sum_res.clip;
        end
    end

    assign acc  = acc_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

### rtl/core/linear_ode_euler_stepper_top.sv
// Channel  Dir  tdata (low bit up)                                    tuser
// s_axis   in   load_index, load_value, coeff_zero..coeff_three,      operation
//               forcing, zero pad to 200 bits
// m_axis   out  solution                                              saturated
// cfg      in   cfg_we / cfg_index (0 order, 1 step) / cfg_data       -
//
// A load request finishes when it is captured; a step request runs capture, lane
// multiplies, merge sum, final multiply by step and write-back in that order,
// set by the dependent multiply, sum, multiply chain through the derivative vector.
// The result waits in an output register; write-back stalls only while an
// earlier result is still untaken.
// Reset clears the derivative vector, order to 1 and step to 66 (Q16.16).
`default_nettype none

module linear_ode_euler_stepper_top
    import les_pkg::*;
#(
    parameter int MAX_ORDER = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // load_index, load_value, coeff0..3, forcing
    input  wire logic                  s_tuser,   // operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // solution
    output logic                       m_tuser,   // saturated
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [Q_W-1:0]        cfg_data
);

    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int CW = (NW > 3) ? NW : 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t          state_reg;
    logic [2:0]      order_reg;
    q_t              step_reg;
    q_t              v_reg [MAX_ORDER];
    logic            m_tvalid_reg;
    q_t              sol_reg;
    logic            sat_reg;

    q_t              coeff_reg [MAX_ORDER];
    q_t              forcing_reg;
    prod_t           fin_prod_reg;

    logic [CW-1:0]          order_ext;
    logic [CW-1:0]          n_eff;
    logic [MAX_ORDER-1:0]   active;
    logic [MAX_ORDER-1:0]   last;
    lane_ctl_t              lane_ctl;
    q_t                     v_up [MAX_ORDER];
    prod_t                  lane_prod [MAX_ORDER];
    q_t                     lane_next [MAX_ORDER];
    logic [MAX_ORDER-1:0]   lane_clip;
    q_t                     merge_acc;
    logic                   merge_clip;
    q_t                     v_last;
    sat_res_t               fin_res;
    logic                   step_clip;
    q_t                     v_new [MAX_ORDER];
    logic                   accept;
    logic                   fin_go;

    assign accept = s_tvalid && s_tready;
    assign fin_go = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        order_ext = CW'(order_reg);
        if (order_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (order_ext > CW'(MAX_ORDER))
        begin
            n_eff = CW'(MAX_ORDER);
        end
        else
        begin
            n_eff = order_ext;
        end
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            active[k] = CW'(k) < n_eff;
            last[k]   = CW'(k + 1) == n_eff;
        end
    end

    assign lane_ctl.mul_en = (state_reg == ST_MUL);
    assign lane_ctl.add_en = (state_reg == ST_SUM);

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_lane
        if (k + 1 < MAX_ORDER)
        begin : g_up
            assign v_up[k] = v_reg[k + 1];
        end
        else
        begin : g_top
            assign v_up[k] = '0;
        end

        les_lane u_lane (
            .clk        (clk),
            .ctl        (lane_ctl),
            .coeff      (coeff_reg[k]),
            .v_self     (v_reg[k]),
            .v_up       (v_up[k]),
            .step       (step_reg),
            .coeff_prod (lane_prod[k]),
            .next_val   (lane_next[k]),
            .clip       (lane_clip[k])
        );
    end

    les_merge #(
        .MAX_ORDER (MAX_ORDER)
    ) u_merge (
        .clk     (clk),
        .sum_en  (lane_ctl.add_en),
        .forcing (forcing_reg),
        .prod    (lane_prod),
        .active  (active),
        .acc     (merge_acc),
        .clip    (merge_clip)
    );

    always_comb
    begin
        v_last = '0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (last[k])
            begin
                v_last = v_reg[k];
            end
        end
        fin_res   = sat_q(64'(v_last) + 64'(fin_prod_reg));
        step_clip = merge_clip || fin_res.clip || (|(lane_clip & active & ~last));
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (last[k])
            begin
                v_new[k] = fin_res.q;
            end
            else if (active[k])
            begin
                v_new[k] = lane_next[k];
            end
            else
            begin
                v_new[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            order_reg    <= 3'd1;
            step_reg     <= 32'sd66;
            m_tvalid_reg <= 1'b0;
            sol_reg      <= '0;
            sat_reg      <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                v_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORDER: order_reg <= cfg_data[2:0];
                    CFG_STEP:  step_reg  <= cfg_data;
                    default:   ;
                endcase
            end
            if (m_tvalid_reg && m_tready && !fin_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == OP_STEP)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            for (int k = 0; k < MAX_ORDER; k++)
                            begin
                                if ({30'd0, s_tdata[1:0]} == k)
                                begin
                                    v_reg[k] <= s_tdata[33:2];
                                end
                            end
                        end
                    end
                end
                ST_MUL:  state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        v_reg        <= v_new;
                        sol_reg      <= v_new[0];
                        sat_reg      <= step_clip;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == OP_STEP))
        begin
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                if (k < NUM_COEFF)
                begin
                    coeff_reg[k] <= s_tdata[34 + 32*k +: 32];
                end
                else
                begin
                    coeff_reg[k] <= '0;
                end
            end
            forcing_reg <= s_tdata[193:162];
        end
        if (state_reg == ST_MUL2)
        begin
            fin_prod_reg <= qmul(merge_acc, step_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = sol_reg;
    assign m_tuser  = sat_reg;

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_STEP) |=> state_reg == ST_MUL)
        else $error("step request did not start the lanes");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_LOAD) |=> !$rose(m_tvalid))
        else $error("load request produced a result");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside write-back");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_tvalid && !m_tready) |=> state_reg == ST_FIN)
        else $error("write-back overran an untaken result");

endmodule

`default_nettype wire
